### src/lsg_pkg.sv
// shared types, constants and helper functions of the lidar sector guard
package lsg_pkg;

   // fixed field widths
   localparam int SPEED_W    = 16;
   localparam int RANGE_W    = 16;
   localparam int KEY_W      = 8;
   localparam int BOUND_W    = 10;
   localparam int CMD_W      = SPEED_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // default scan length and decoupling queue depth
   localparam int SCAN_LEN_DEF = 721;
   localparam int QUEUE_DEPTH  = 4;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RIGHT_END    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FRONT_START  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_FRONT_END    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LEFT_START   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESET_DRIVE = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESET_TURN  = 3'd6;

   // register reset values
   localparam logic [RANGE_W-1:0] THRESHOLD_RST    = 16'd1000;
   localparam logic [BOUND_W-1:0] RIGHT_END_RST    = 10'd159;
   localparam logic [BOUND_W-1:0] FRONT_START_RST  = 10'd281;
   localparam logic [BOUND_W-1:0] FRONT_END_RST    = 10'd440;
   localparam logic [BOUND_W-1:0] LEFT_START_RST   = 10'd561;
   localparam logic [SPEED_W-1:0] PRESET_DRIVE_RST = 16'd512;
   localparam logic [SPEED_W-1:0] PRESET_TURN_RST  = 16'd1024;

   // state reset values
   localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST = 16'd205;
   localparam logic [SPEED_W-1:0] TURN_SPEED_RST  = 16'd512;
   localparam logic [RANGE_W-1:0] MIN_START       = 16'd30000;
   localparam logic [SPEED_W-1:0] SPEED_MAX       = 16'hFFFF;

   // reciprocal of ten, exact for operands below 2**18
   localparam int RECIP_SHIFT = 19;
   localparam logic [SPEED_W-1:0] RECIP_TEN = 16'd52429;

   // operations handed from the front to the back
   typedef logic [3:0] op_type;
   localparam op_type OP_SAMPLE  = 4'd0;
   localparam op_type OP_UP_BOTH = 4'd1;
   localparam op_type OP_DN_BOTH = 4'd2;
   localparam op_type OP_UP_DRV  = 4'd3;
   localparam op_type OP_DN_DRV  = 4'd4;
   localparam op_type OP_UP_TRN  = 4'd5;
   localparam op_type OP_DN_TRN  = 4'd6;
   localparam op_type OP_PRESET  = 4'd7;
   localparam op_type OP_DIRS    = 4'd8;
   localparam op_type OP_QUIT    = 4'd9;

   // motion direction, -1, 0 or +1
   typedef logic signed [1:0] dir_type;
   localparam dir_type DIR_POS  = 2'sb01;
   localparam dir_type DIR_NONE = 2'sb00;
   localparam dir_type DIR_NEG  = 2'sb11;

   // one classified word in the queue
   typedef struct packed {
      op_type               op;
      dir_type              drv_dir;
      dir_type              trn_dir;
      logic [RANGE_W-1:0]   range_mm;
      logic                 scan_start;
   } entry_type;

   // configuration register set
   typedef struct packed {
      logic [RANGE_W-1:0] threshold_mm;
      logic [BOUND_W-1:0] right_end;
      logic [BOUND_W-1:0] front_start;
      logic [BOUND_W-1:0] front_end;
      logic [BOUND_W-1:0] left_start;
      logic [SPEED_W-1:0] preset_drive_speed;
      logic [SPEED_W-1:0] preset_turn_speed;
   } cfg_type;

   // floor(x / 10) for x below 2**18
   function automatic logic [SPEED_W:0] div_ten(input logic [SPEED_W:0] x);
      logic [SPEED_W+SPEED_W+1:0] prod;
      prod = x * RECIP_TEN;
      return (SPEED_W+1)'(prod >> RECIP_SHIFT);
   endfunction

   // floor(s * 11 / 10), saturating
   function automatic logic [SPEED_W-1:0] scale_up(input logic [SPEED_W-1:0] s);
      logic [SPEED_W:0] sum;
      sum = {1'b0, s} + div_ten({1'b0, s});
      return sum[SPEED_W] ? SPEED_MAX : sum[SPEED_W-1:0];
   endfunction

   // floor(s * 9 / 10) = s - ceil(s / 10)
   function automatic logic [SPEED_W-1:0] scale_down(input logic [SPEED_W-1:0] s);
      logic [SPEED_W:0] q;
      q = div_ten({1'b0, s} + (SPEED_W+1)'(9));
      return s - q[SPEED_W-1:0];
   endfunction

   // speed times direction
   function automatic logic signed [CMD_W-1:0] signed_cmd(input logic [SPEED_W-1:0] speed,
                                                          input dir_type dir);
      logic signed [CMD_W-1:0] mag;
      mag = signed'({1'b0, speed});
      if (dir == DIR_POS) return mag;
      else if (dir == DIR_NEG) return -mag;
      else return '0;
   endfunction

   // key code to operation, case-insensitive
   function automatic entry_type decode_key(input logic [KEY_W-1:0] key);
      entry_type        e;
      logic [KEY_W-1:0] low;
      low = (key >= "A" && key <= "Z") ? key + 8'd32 : key;
      e = '0;
      e.op = OP_DIRS;
      e.drv_dir = DIR_NONE;
      e.trn_dir = DIR_NONE;
      unique case (low)
         "a": e.op = OP_UP_BOTH;
         "d": e.op = OP_DN_BOTH;
         "w": e.op = OP_UP_DRV;
         "s": e.op = OP_DN_DRV;
         "q": e.op = OP_UP_TRN;
         "c": e.op = OP_DN_TRN;
         "r": e.op = OP_PRESET;
         "e": e.op = OP_QUIT;
         "y": begin e.drv_dir = DIR_POS;  e.trn_dir = DIR_POS;  end
         "u": begin e.drv_dir = DIR_POS;  e.trn_dir = DIR_NONE; end
         "i": begin e.drv_dir = DIR_POS;  e.trn_dir = DIR_NEG;  end
         "h": begin e.drv_dir = DIR_NONE; e.trn_dir = DIR_POS;  end
         "j": begin e.drv_dir = DIR_NONE; e.trn_dir = DIR_NONE; end
         "k": begin e.drv_dir = DIR_NONE; e.trn_dir = DIR_NEG;  end
         "b": begin e.drv_dir = DIR_NEG;  e.trn_dir = DIR_POS;  end
         "n": begin e.drv_dir = DIR_NEG;  e.trn_dir = DIR_NONE; end
         "m": begin e.drv_dir = DIR_NEG;  e.trn_dir = DIR_NEG;  end
         default: e.op = OP_DIRS;
      endcase
      return e;
   endfunction

endpackage

### src/lsg_if.sv
// request and response channel interfaces of the lidar sector guard
interface lsg_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  key_code;
   logic [15:0] range_mm;
   logic        scan_start;

   modport source (output valid, req_type, key_code, range_mm, scan_start, input ready);
   modport sink   (input valid, req_type, key_code, range_mm, scan_start, output ready);
endinterface

interface lsg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] drive_cmd;
   logic signed [16:0] turn_cmd;
   logic               wall_warning;
   logic               from_scan;
   logic               halted;

   modport source (output valid, drive_cmd, turn_cmd, wall_warning, from_scan, halted,
                   input ready);
   modport sink   (input valid, drive_cmd, turn_cmd, wall_warning, from_scan, halted,
                   output ready);
endinterface

### src/lsg_front.sv
// front end: accepts request words, classifies them and feeds the queue
module lsg_front (
   input  logic                clock,
   input  logic                reset,
   lsg_req_if.sink             req_ch,
   output logic                push,
   output lsg_pkg::entry_type  push_data,
   input  logic                q_full
);
   import lsg_pkg::*;

   logic      stg_vld_ff, stg_vld_in;
   entry_type stg_ff, stg_in;
   logic      accept;

   // stage is free when empty or draining into the queue
   assign push         = stg_vld_ff && !q_full;
   assign req_ch.ready = !stg_vld_ff || !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_data    = stg_ff;

   // classify the incoming word
   always_comb begin
      if (req_ch.req_type) begin
         stg_in            = '0;
         stg_in.op         = OP_SAMPLE;
         stg_in.range_mm   = req_ch.range_mm;
         stg_in.scan_start = req_ch.scan_start;
      end else begin
         stg_in = decode_key(req_ch.key_code);
      end
   end

   assign stg_vld_in = accept || (stg_vld_ff && !push);

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= stg_vld_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
   end

endmodule

### src/lsg_queue.sv
// short fifo between front and back
module lsg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lsg_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output lsg_pkg::entry_type  pop_data,
   output logic                empty
);
   import lsg_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;

   assign full     = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/lsg_back.sv
// back end: speed and direction state, sector minima and the response register
module lsg_back #(
   parameter int SCAN_LEN = lsg_pkg::SCAN_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lsg_pkg::cfg_type    cfg,
   input  lsg_pkg::entry_type  head,
   input  logic                empty,
   output logic                pop,
   lsg_rsp_if.source           rsp_ch
);
   import lsg_pkg::*;

   localparam int IDX_W = $clog2(SCAN_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LEN - 1);

   // architectural state
   logic [SPEED_W-1:0] drv_speed_ff, drv_speed_in;
   logic [SPEED_W-1:0] trn_speed_ff, trn_speed_in;
   dir_type            drv_dir_ff, drv_dir_in;
   dir_type            trn_dir_ff, trn_dir_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [RANGE_W-1:0] min_r_ff, min_r_in;
   logic [RANGE_W-1:0] min_f_ff, min_f_in;
   logic [RANGE_W-1:0] min_l_ff, min_l_in;
   logic               quit_ff, quit_in;

   // response register
   logic                    out_vld_ff, out_vld_in;
   logic signed [CMD_W-1:0] out_drv_ff, out_drv_in;
   logic signed [CMD_W-1:0] out_trn_ff, out_trn_in;
   logic                    out_warn_ff, out_warn_in;
   logic                    out_scan_ff, out_scan_in;
   logic                    out_halt_ff, out_halt_in;

   logic               is_sample, last, produces, out_free, load;
   logic [IDX_W-1:0]   idx_eff;
   logic [RANGE_W-1:0] min_r_eff, min_f_eff, min_l_eff;
   logic [RANGE_W-1:0] min_r_new, min_f_new, min_l_new;
   logic [BOUND_W-1:0] idx_ext;
   logic               blk_f, blk_l, blk_r, drv_stop, trn_stop;
   logic [SPEED_W-1:0] drv_up, drv_dn, trn_up, trn_dn;

   // sample path: restart on scan mark, then fold into the sector minima
   assign is_sample = (head.op == OP_SAMPLE);
   assign idx_eff   = head.scan_start ? '0 : idx_ff;
   assign min_r_eff = head.scan_start ? MIN_START : min_r_ff;
   assign min_f_eff = head.scan_start ? MIN_START : min_f_ff;
   assign min_l_eff = head.scan_start ? MIN_START : min_l_ff;
   assign idx_ext   = BOUND_W'(idx_eff);

   assign min_r_new = (idx_ext <= cfg.right_end && head.range_mm <= min_r_eff)
                      ? head.range_mm : min_r_eff;
   assign min_f_new = (idx_ext >= cfg.front_start && idx_ext <= cfg.front_end &&
                       head.range_mm <= min_f_eff) ? head.range_mm : min_f_eff;
   assign min_l_new = (idx_ext >= cfg.left_start && head.range_mm <= min_l_eff)
                      ? head.range_mm : min_l_eff;
   assign last      = (idx_eff == LAST_IDX);

   // sector guard at scan end
   assign blk_f    = min_f_new < cfg.threshold_mm;
   assign blk_l    = min_l_new < cfg.threshold_mm;
   assign blk_r    = min_r_new < cfg.threshold_mm;
   assign drv_stop = blk_f && (drv_dir_ff == DIR_POS);
   assign trn_stop = (blk_l && (trn_dir_ff == DIR_POS)) || (blk_r && (trn_dir_ff == DIR_NEG));

   // speed scaling
   assign drv_up = scale_up(drv_speed_ff);
   assign drv_dn = scale_down(drv_speed_ff);
   assign trn_up = scale_up(trn_speed_ff);
   assign trn_dn = scale_down(trn_speed_ff);

   // pop whenever the word needs no response slot or the slot frees up
   assign produces = !is_sample || (!quit_ff && last);
   assign out_free = !out_vld_ff || rsp_ch.ready;
   assign pop      = !empty && (!produces || out_free);
   assign load     = pop && produces;

   // next state and response
   always_comb begin
      drv_speed_in = drv_speed_ff;
      trn_speed_in = trn_speed_ff;
      drv_dir_in   = drv_dir_ff;
      trn_dir_in   = trn_dir_ff;
      idx_in       = idx_ff;
      min_r_in     = min_r_ff;
      min_f_in     = min_f_ff;
      min_l_in     = min_l_ff;
      quit_in      = quit_ff;
      out_warn_in  = 1'b0;
      out_scan_in  = 1'b0;
      out_halt_in  = 1'b0;
      if (pop && !quit_ff) begin
         unique case (head.op)
            OP_SAMPLE: begin
               if (last) begin
                  drv_dir_in  = drv_stop ? DIR_NONE : drv_dir_ff;
                  trn_dir_in  = trn_stop ? DIR_NONE : trn_dir_ff;
                  out_warn_in = drv_stop || trn_stop;
                  out_scan_in = 1'b1;
                  idx_in      = '0;
                  min_r_in    = MIN_START;
                  min_f_in    = MIN_START;
                  min_l_in    = MIN_START;
               end else begin
                  idx_in   = idx_eff + 1'b1;
                  min_r_in = min_r_new;
                  min_f_in = min_f_new;
                  min_l_in = min_l_new;
               end
            end
            OP_UP_BOTH: begin
               drv_speed_in = drv_up;
               trn_speed_in = trn_up;
            end
            OP_DN_BOTH: begin
               drv_speed_in = drv_dn;
               trn_speed_in = trn_dn;
            end
            OP_UP_DRV: drv_speed_in = drv_up;
            OP_DN_DRV: drv_speed_in = drv_dn;
            OP_UP_TRN: trn_speed_in = trn_up;
            OP_DN_TRN: trn_speed_in = trn_dn;
            OP_PRESET: begin
               drv_speed_in = cfg.preset_drive_speed;
               trn_speed_in = cfg.preset_turn_speed;
            end
            OP_DIRS: begin
               drv_dir_in = head.drv_dir;
               trn_dir_in = head.trn_dir;
            end
            OP_QUIT: begin
               quit_in     = 1'b1;
               out_halt_in = 1'b1;
            end
            default: begin
               drv_dir_in = DIR_NONE;
               trn_dir_in = DIR_NONE;
            end
         endcase
      end else if (quit_ff) begin
         out_halt_in = 1'b1;
      end
      if (out_halt_in) begin
         out_drv_in = '0;
         out_trn_in = '0;
      end else begin
         out_drv_in = signed_cmd(drv_speed_in, drv_dir_in);
         out_trn_in = signed_cmd(trn_speed_in, trn_dir_in);
      end
   end

   assign out_vld_in = load || (out_vld_ff && !rsp_ch.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         drv_speed_ff <= DRIVE_SPEED_RST;
         trn_speed_ff <= TURN_SPEED_RST;
         drv_dir_ff   <= DIR_NONE;
         trn_dir_ff   <= DIR_NONE;
         idx_ff       <= '0;
         min_r_ff     <= MIN_START;
         min_f_ff     <= MIN_START;
         min_l_ff     <= MIN_START;
         quit_ff      <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         drv_speed_ff <= drv_speed_in;
         trn_speed_ff <= trn_speed_in;
         drv_dir_ff   <= drv_dir_in;
         trn_dir_ff   <= trn_dir_in;
         idx_ff       <= idx_in;
         min_r_ff     <= min_r_in;
         min_f_ff     <= min_f_in;
         min_l_ff     <= min_l_in;
         quit_ff      <= quit_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_drv_ff  <= out_drv_in;
         out_trn_ff  <= out_trn_in;
         out_warn_ff <= out_warn_in;
         out_scan_ff <= out_scan_in;
         out_halt_ff <= out_halt_in;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.drive_cmd    = out_drv_ff;
   assign rsp_ch.turn_cmd     = out_trn_ff;
   assign rsp_ch.wall_warning = out_warn_ff;
   assign rsp_ch.from_scan    = out_scan_ff;
   assign rsp_ch.halted       = out_halt_ff;

`ifndef NO_ASSERTIONS
   // a scan result never comes out of the halted state
   a_scan_not_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.from_scan |-> !rsp_ch.halted)
      else $error("scan word while halted");

   // a halted word carries a zero command
   a_halted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.halted |-> rsp_ch.drive_cmd == '0 && rsp_ch.turn_cmd == '0)
      else $error("halted word with motion");

   // key words never carry a warning
   a_key_no_warn: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.from_scan |-> !rsp_ch.wall_warning)
      else $error("warning on key word");

   // a mid-scan sample advances the index by one
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      pop && is_sample && !quit_ff && !last |=> idx_ff == $past(idx_eff) + 1'b1)
      else $error("sample index did not advance");
`endif

endmodule

### src/lidar_sector_guard_teleop.sv
// top level of the teleop command generator with lidar sector guard
//
//   channel  dir  handshake       payload
//   req_ch   in   valid/ready     req_type, key_code, range_mm, scan_start
//   rsp_ch   out  valid/ready     drive_cmd, turn_cmd, wall_warning, from_scan, halted
//   csr_*    in   write enable    csr_index, csr_wdata (no read-back)
//
// one word per cycle unless a waiting response on rsp_ch backs up the queue: a classify
// stage, a four-entry queue and the back end that updates state and the response
// register in the same cycle; a key word passes the stage, the queue, then that register.
// synchronous reset restores speeds, directions, minima and registers; no clearing pass.
// the queue lets requests keep flowing while a response waits on rsp_ch.ready.
module lidar_sector_guard_teleop #(
   parameter int SCAN_LEN = lsg_pkg::SCAN_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lsg_req_if.sink                           req_ch,
   lsg_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [lsg_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [lsg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lsg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push, q_full, pop, q_empty;
   entry_type push_data, pop_data;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_THRESHOLD:    cfg_in.threshold_mm       = csr_wdata;
            REG_RIGHT_END:    cfg_in.right_end          = csr_wdata[BOUND_W-1:0];
            REG_FRONT_START:  cfg_in.front_start        = csr_wdata[BOUND_W-1:0];
            REG_FRONT_END:    cfg_in.front_end          = csr_wdata[BOUND_W-1:0];
            REG_LEFT_START:   cfg_in.left_start         = csr_wdata[BOUND_W-1:0];
            REG_PRESET_DRIVE: cfg_in.preset_drive_speed = csr_wdata;
            REG_PRESET_TURN:  cfg_in.preset_turn_speed  = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_mm       <= THRESHOLD_RST;
         cfg_ff.right_end          <= RIGHT_END_RST;
         cfg_ff.front_start        <= FRONT_START_RST;
         cfg_ff.front_end          <= FRONT_END_RST;
         cfg_ff.left_start         <= LEFT_START_RST;
         cfg_ff.preset_drive_speed <= PRESET_DRIVE_RST;
         cfg_ff.preset_turn_speed  <= PRESET_TURN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify
   lsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   // decoupling queue
   lsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // execute and respond
   lsg_back #(
      .SCAN_LEN (SCAN_LEN)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .head   (pop_data),
      .empty  (q_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the teleop command generator with lidar sector guard
module tb_top;
   import lsg_pkg::*;

   localparam int SCAN_TOTAL    = SCAN_LEN_DEF;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_PCT      = 11;
   localparam int MAX_REPORTS   = 40;

   // word kinds on the request channel
   localparam logic REQ_KEY    = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // index with no register behind it
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;

   // how range values of one scan are spread
   localparam int SPREAD_FULL    = 0;
   localparam int SPREAD_CLEAR   = 1;
   localparam int SPREAD_EXTREME = 2;
   localparam int SPREAD_NEAR    = 3;

   typedef struct packed {
      logic               req_type;
      logic [KEY_W-1:0]   key_code;
      logic [RANGE_W-1:0] range_mm;
      logic               scan_start;
   } req_word_type;

   typedef struct packed {
      logic [CMD_W-1:0] drive;
      logic [CMD_W-1:0] turn;
      logic             warn;
      logic             from_scan;
      logic             halted;
   } cmd_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lsg_req_if req_ch ();
   lsg_rsp_if rsp_ch ();

   lidar_sector_guard_teleop #(
      .SCAN_LEN (SCAN_TOTAL)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   req_word_type pending_words [$];
   cmd_word_type cmd_forecast_q [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   logic         steady;

   // both sides run without idling for part of every window
   assign steady = (cycle_count % 2000) >= 1400;

   // mirror of the block's registers and state
   cfg_type            guard_cfg;
   logic [SPEED_W-1:0] spd_drive, spd_turn;
   dir_type            dir_drive, dir_turn;
   logic [BOUND_W-1:0] scan_pos;
   logic [RANGE_W-1:0] near_right, near_front, near_left;
   logic               quit_seen;

   string dir_keys   = "yuihjkbnm";
   string speed_keys = "adwsqcr";

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor of s * 11 / 10, saturating
   function automatic logic [SPEED_W-1:0] grow(input logic [SPEED_W-1:0] s);
      int unsigned v;
      v = s;
      v = v * 11 / 10;
      return (v > SPEED_MAX) ? SPEED_MAX : v[SPEED_W-1:0];
   endfunction

   // floor of s * 9 / 10
   function automatic logic [SPEED_W-1:0] shrink(input logic [SPEED_W-1:0] s);
      int unsigned v;
      v = s;
      v = v * 9 / 10;
      return v[SPEED_W-1:0];
   endfunction

   function automatic logic [CMD_W-1:0] motion(input logic [SPEED_W-1:0] speed,
                                                input dir_type dir);
      int m;
      m = int'(speed) * int'(dir);
      return m[CMD_W-1:0];
   endfunction

   function automatic void clear_near();
      near_right = MIN_START;
      near_front = MIN_START;
      near_left  = MIN_START;
      scan_pos   = '0;
   endfunction

   // advance the mirror by one accepted word and queue the command it causes
   task automatic guard_step(input req_word_type w);
      cmd_word_type       c;
      logic [KEY_W-1:0]   k;
      logic [BOUND_W-1:0] idx;
      logic               blk_front, blk_left, blk_right, stop_drive, stop_turn;
      c = '0;
      if (quit_seen) begin
         if (w.req_type == REQ_KEY) begin
            c.halted = 1'b1;
            cmd_forecast_q.push_back(c);
         end
         return;
      end
      if (w.req_type == REQ_KEY) begin
         k = w.key_code;
         if (k >= "A" && k <= "Z") k = k + 8'd32;
         case (k)
            "a": begin
               spd_drive = grow(spd_drive);
               spd_turn  = grow(spd_turn);
            end
            "d": begin
               spd_drive = shrink(spd_drive);
               spd_turn  = shrink(spd_turn);
            end
            "w": spd_drive = grow(spd_drive);
            "s": spd_drive = shrink(spd_drive);
            "q": spd_turn = grow(spd_turn);
            "c": spd_turn = shrink(spd_turn);
            "r": begin
               spd_drive = guard_cfg.preset_drive_speed;
               spd_turn  = guard_cfg.preset_turn_speed;
            end
            "y": begin dir_drive = DIR_POS;  dir_turn = DIR_POS;  end
            "u": begin dir_drive = DIR_POS;  dir_turn = DIR_NONE; end
            "i": begin dir_drive = DIR_POS;  dir_turn = DIR_NEG;  end
            "h": begin dir_drive = DIR_NONE; dir_turn = DIR_POS;  end
            "j": begin dir_drive = DIR_NONE; dir_turn = DIR_NONE; end
            "k": begin dir_drive = DIR_NONE; dir_turn = DIR_NEG;  end
            "b": begin dir_drive = DIR_NEG;  dir_turn = DIR_POS;  end
            "n": begin dir_drive = DIR_NEG;  dir_turn = DIR_NONE; end
            "m": begin dir_drive = DIR_NEG;  dir_turn = DIR_NEG;  end
            "e": begin
               quit_seen = 1'b1;
               c.halted  = 1'b1;
               cmd_forecast_q.push_back(c);
               return;
            end
            default: begin dir_drive = DIR_NONE; dir_turn = DIR_NONE; end
         endcase
         c.drive = motion(spd_drive, dir_drive);
         c.turn  = motion(spd_turn, dir_turn);
         cmd_forecast_q.push_back(c);
         return;
      end
      // range sample: mark restarts the scan before the sample is taken in
      if (w.scan_start) clear_near();
      idx = scan_pos;
      if (idx <= guard_cfg.right_end && w.range_mm <= near_right) near_right = w.range_mm;
      if (idx >= guard_cfg.front_start && idx <= guard_cfg.front_end &&
          w.range_mm <= near_front) near_front = w.range_mm;
      if (idx >= guard_cfg.left_start && w.range_mm <= near_left) near_left = w.range_mm;
      if (idx < SCAN_TOTAL - 1) begin
         scan_pos = idx + 1'b1;
         return;
      end
      // end of scan: warning uses the directions before they are cleared
      blk_front  = near_front < guard_cfg.threshold_mm;
      blk_left   = near_left < guard_cfg.threshold_mm;
      blk_right  = near_right < guard_cfg.threshold_mm;
      stop_drive = blk_front && dir_drive == DIR_POS;
      stop_turn  = (blk_left && dir_turn == DIR_POS) || (blk_right && dir_turn == DIR_NEG);
      if (stop_drive) dir_drive = DIR_NONE;
      if (stop_turn) dir_turn = DIR_NONE;
      c.drive     = motion(spd_drive, dir_drive);
      c.turn      = motion(spd_turn, dir_turn);
      c.warn      = stop_drive | stop_turn;
      c.from_scan = 1'b1;
      cmd_forecast_q.push_back(c);
      clear_near();
   endtask

   task automatic report_field(input string what, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      end
   endtask

   // request driver: one word in flight, held until taken
   always @(posedge clock) begin : req_driver
      req_word_type w;
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.req_type   <= REQ_KEY;
         req_ch.key_code   <= '0;
         req_ch.range_mm   <= '0;
         req_ch.scan_start <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            guard_step({req_ch.req_type, req_ch.key_code, req_ch.range_mm, req_ch.scan_start});
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               w = pending_words.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.req_type   <= w.req_type;
               req_ch.key_code   <= w.key_code;
               req_ch.range_mm   <= w.range_mm;
               req_ch.scan_start <= w.scan_start;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin : rsp_monitor
      cmd_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (cmd_forecast_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: command expected none actual drive %0d turn %0d", $time,
                           rsp_ch.drive_cmd, rsp_ch.turn_cmd);
            end else begin
               want = cmd_forecast_q.pop_front();
               report_field("drive_cmd", $signed(want.drive), rsp_ch.drive_cmd);
               report_field("turn_cmd", $signed(want.turn), rsp_ch.turn_cmd);
               report_field("wall_warning", want.warn, rsp_ch.wall_warning);
               report_field("from_scan", want.from_scan, rsp_ch.from_scan);
               report_field("halted", want.halted, rsp_ch.halted);
            end
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lidar_sector_guard_teleop test failed");
         $finish;
      end
   end

   task automatic push_key(input logic [KEY_W-1:0] k);
      req_word_type w;
      w.req_type   = REQ_KEY;
      w.key_code   = k;
      w.range_mm   = RANGE_W'($urandom_range(0, 65535));
      w.scan_start = 1'($urandom_range(0, 1));
      pending_words.push_back(w);
   endtask

   task automatic push_keys(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_key(s[i]);
   endtask

   task automatic push_sample(input logic [RANGE_W-1:0] r, input logic mark);
      req_word_type w;
      w.req_type   = REQ_SAMPLE;
      w.key_code   = KEY_W'($urandom_range(0, 255));
      w.range_mm   = r;
      w.scan_start = mark;
      pending_words.push_back(w);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      int               pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         k = dir_keys[$urandom_range(0, dir_keys.len() - 1)];
      end else if (pick < 8) begin
         k = speed_keys[$urandom_range(0, speed_keys.len() - 1)];
      end else begin
         // any byte, but the quit key is kept for the end of the run
         k = KEY_W'($urandom_range(0, 255));
         if (k == "e" || k == "E") k = k ^ 8'h01;
         return k;
      end
      if ($urandom_range(0, 1) == 1) k = k - 8'd32;
      return k;
   endfunction

   function automatic logic [RANGE_W-1:0] pick_range(input int spread);
      int unsigned thr;
      thr = guard_cfg.threshold_mm;
      case (spread)
         SPREAD_FULL: return RANGE_W'($urandom_range(0, 65535));
         SPREAD_CLEAR: begin
            // mostly clear, with rare dips right at the threshold
            if ($urandom_range(0, 149) == 0)
               return (thr == 0) ? '0 : RANGE_W'(thr - $urandom_range(0, 1));
            return RANGE_W'($urandom_range(thr, 65535));
         end
         SPREAD_EXTREME: return ($urandom_range(0, 199) == 0) ? '0 : RANGE_W'(65535);
         default: return RANGE_W'($urandom_range(0, (thr * 2 > 65535) ? 65535 : thr * 2));
      endcase
   endfunction

   // wait until the block has nothing left to do
   task automatic settle();
      while (pending_words.size() != 0 || req_ch.valid || cmd_forecast_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_THRESHOLD:    guard_cfg.threshold_mm = val;
         REG_RIGHT_END:    guard_cfg.right_end = val[BOUND_W-1:0];
         REG_FRONT_START:  guard_cfg.front_start = val[BOUND_W-1:0];
         REG_FRONT_END:    guard_cfg.front_end = val[BOUND_W-1:0];
         REG_LEFT_START:   guard_cfg.left_start = val[BOUND_W-1:0];
         REG_PRESET_DRIVE: guard_cfg.preset_drive_speed = val;
         REG_PRESET_TURN:  guard_cfg.preset_turn_speed = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setup(input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] re,
                              input logic [CSR_DATA_W-1:0] fs, input logic [CSR_DATA_W-1:0] fe,
                              input logic [CSR_DATA_W-1:0] ls, input logic [CSR_DATA_W-1:0] pd,
                              input logic [CSR_DATA_W-1:0] pt);
      settle();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_RIGHT_END, re);
      write_reg(REG_FRONT_START, fs);
      write_reg(REG_FRONT_END, fe);
      write_reg(REG_LEFT_START, ls);
      write_reg(REG_PRESET_DRIVE, pd);
      write_reg(REG_PRESET_TURN, pt);
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom_range(0, 65535)));
   endtask

   // key bursts and cut-off sample runs, then whole scans led by a direction key
   task automatic run_phase(input int scans, input int mixes);
      int               pick, spread, i, j, n;
      logic [KEY_W-1:0] k;
      push_keys("r");
      for (j = 0; j < mixes; j++) begin
         pick   = $urandom_range(0, 1);
         spread = $urandom_range(SPREAD_FULL, SPREAD_NEAR);
         if (pick == 0) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) push_key(pick_key());
         end else begin
            // short run of samples, sometimes restarting the scan
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
               push_sample(pick_range(spread), i == 0 && $urandom_range(0, 1) == 1);
         end
      end
      for (j = 0; j < scans; j++) begin
         spread = $urandom_range(SPREAD_FULL, SPREAD_NEAR);
         k = dir_keys[$urandom_range(0, dir_keys.len() - 1)];
         if ($urandom_range(0, 1) == 1) k = k - 8'd32;
         push_key(k);
         for (i = 0; i < SCAN_TOTAL; i++) begin
            if ($urandom_range(0, 199) == 0) push_key(pick_key());
            push_sample(pick_range(spread), i == 0);
         end
      end
   endtask

   initial begin : stimulus
      int i;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      // mirror starts from the reset state
      guard_cfg.threshold_mm       = THRESHOLD_RST;
      guard_cfg.right_end          = RIGHT_END_RST;
      guard_cfg.front_start        = FRONT_START_RST;
      guard_cfg.front_end          = FRONT_END_RST;
      guard_cfg.left_start         = LEFT_START_RST;
      guard_cfg.preset_drive_speed = PRESET_DRIVE_RST;
      guard_cfg.preset_turn_speed  = PRESET_TURN_RST;
      spd_drive = DRIVE_SPEED_RST;
      spd_turn  = TURN_SPEED_RST;
      dir_drive = DIR_NONE;
      dir_turn  = DIR_NONE;
      quit_seen = 1'b0;
      clear_near();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // keys in mixed case except r and e, an unknown code and the bytes 00, FF and 80
      push_keys("uADwsqcyihjkbnmz");
      push_key(8'h00);
      push_key(8'hFF);
      push_key(8'h80);
      settle();
      // saturation at full preset speed and the most negative commands
      write_reg(REG_PRESET_DRIVE, 16'hFFFF);
      write_reg(REG_PRESET_TURN, 16'hFFFF);
      push_keys("rWnY");
      settle();
      // zero speeds
      write_reg(REG_PRESET_DRIVE, '0);
      write_reg(REG_PRESET_TURN, '0);
      push_keys("Rdy");

      // default sectors
      apply_setup(THRESHOLD_RST, RIGHT_END_RST, FRONT_START_RST, FRONT_END_RST,
                  LEFT_START_RST, PRESET_DRIVE_RST, PRESET_TURN_RST);
      run_phase(1, 2);
      // every sector blocked, single-sample left sector
      apply_setup(16'hFFFF, 16'd0, 16'd0, 16'd1023, 16'd720, 16'hFFFF, 16'hFFFF);
      run_phase(1, 2);
      // nothing blocked, crossed front, left beyond the scan
      apply_setup(16'd0, 16'd1023, 16'd1023, 16'd0, 16'd1023, 16'd0, 16'hFFFF);
      run_phase(0, 3);
      apply_setup(CSR_DATA_W'($urandom_range(0, 4000)), CSR_DATA_W'($urandom_range(0, 1023)),
                  CSR_DATA_W'($urandom_range(0, 1023)), CSR_DATA_W'($urandom_range(0, 1023)),
                  CSR_DATA_W'($urandom_range(0, 1023)), CSR_DATA_W'($urandom_range(0, 65535)),
                  CSR_DATA_W'($urandom_range(0, 65535)));
      run_phase(0, 3);
      // empty front keeps its start value, which is just below the threshold
      apply_setup(16'd30001, 16'd719, 16'd800, 16'd900, 16'd0, 16'd300, 16'd700);
      run_phase(0, 3);
      apply_setup(CSR_DATA_W'($urandom_range(500, 3000)), CSR_DATA_W'($urandom_range(100, 300)),
                  CSR_DATA_W'($urandom_range(250, 350)), CSR_DATA_W'($urandom_range(350, 500)),
                  CSR_DATA_W'($urandom_range(450, 720)), CSR_DATA_W'($urandom_range(0, 65535)),
                  CSR_DATA_W'($urandom_range(0, 65535)));
      run_phase(0, 3);

      // quit, then keys give zero halted commands and samples give nothing
      settle();
      push_keys("eEru");
      for (i = 0; i < 16; i++) push_sample(pick_range(SPREAD_FULL), i == 0);
      push_keys("ya");
      settle();

      if (mismatch_count == 0 && cmd_forecast_q.size() == 0)
         $display("lidar_sector_guard_teleop test passed");
      else
         $display("lidar_sector_guard_teleop test failed");
      $finish;
   end

endmodule
